// ===== rtl/core/text_cell_to_ansi_escape_defines.svh =====
// Assertion macros for the checker file of the text cell converter.
`ifndef TEXT_CELL_TO_ANSI_ESCAPE_DEFINES_SVH
`define TEXT_CELL_TO_ANSI_ESCAPE_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define TCAE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define TCAE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/tcae_pkg.sv =====
// Types, constants and helpers for the text cell to terminal stream converter.
package tcae_pkg;

	localparam int unsigned COLUMNS = 80;
	localparam int unsigned ROWS    = 25;

	localparam int unsigned COL_W = 7;
	localparam int unsigned ROW_W = 5;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_ESC  = 8'h1b;
	localparam logic [7:0] CH_LBR  = 8'h5b;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_FG   = 8'h33;
	localparam logic [7:0] CH_BG   = 8'h34;
	localparam logic [7:0] CH_M    = 8'h6d;
	localparam logic [7:0] CH_NL   = 8'h0a;

	// One classified cell, handed from the front end to the emitter.
	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] attr;
		logic       chg;  // attribute differs: emit both color sequences
		logic       eol;  // row ends after this cell
		logic       eos;  // screen ends after this cell
	} cmd_t;

	typedef enum logic [2:0] {
		PH_FG,
		PH_BG,
		PH_CHAR,
		PH_RST1,
		PH_RST2
	} phase_t;

	// CGA color order to ANSI color order.
	function automatic logic [2:0] ansi_of_cga(input logic [2:0] c);
		logic [2:0] r;
		unique case (c)
			3'd0:    r = 3'd0;
			3'd1:    r = 3'd4;
			3'd2:    r = 3'd2;
			3'd3:    r = 3'd6;
			3'd4:    r = 3'd1;
			3'd5:    r = 3'd5;
			3'd6:    r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/tcae_front.sv =====
// Front end: tracks attribute, column and row, classifies each cell.
module tcae_front import tcae_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] cell_char,
	input  logic [7:0] cell_attr,
	output cmd_t       cmd
);

	logic [7:0]       attr_q;
	logic [COL_W-1:0] column_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	logic             eol;
	logic             eos;

	assign col_inc = {1'b0, column_q} + (COL_W+1)'(1);
	assign row_inc = {1'b0, row_q} + (ROW_W+1)'(1);
	assign eol     = col_inc >= (COL_W+1)'(COLUMNS);
	assign eos     = eol && (row_inc >= (ROW_W+1)'(ROWS));

	assign cmd.ch   = cell_char;
	assign cmd.attr = cell_attr;
	assign cmd.chg  = cell_attr != attr_q;
	assign cmd.eol  = eol;
	assign cmd.eos  = eos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q   <= '0;
			column_q <= '0;
			row_q    <= '0;
		end else if (accept) begin
			// a line end drops the attribute back to zero
			attr_q   <= eol ? 8'h00 : cell_attr;
			column_q <= eol ? '0 : col_inc[COL_W-1:0];
			if (eol) begin
				row_q <= eos ? '0 : row_inc[ROW_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/core/tcae_fifo.sv =====
// Short command queue between the front end and the emitter.
module tcae_fifo import tcae_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic full,
	input  logic rd,
	output cmd_t rdata,
	output logic empty
);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full  = cnt_q == FIFO_CW'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + FIFO_AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + FIFO_AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + FIFO_CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - FIFO_CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/tcae_back.sv =====
// Emitter: expands one command into terminal bytes, one per cycle unless a held output byte is not popped.
module tcae_back import tcae_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cmd_empty,
	output logic       cmd_take,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_byte
);

	logic       busy_q;
	cmd_t       cur_q;
	phase_t     ph_q;
	phase_t     ph_d;
	logic [2:0] sub_q;
	logic [2:0] sub_d;
	logic       ov_q;
	logic [7:0] ob_q;
	logic       ol_q;

	logic [7:0] byte_c;
	logic       is_last;
	logic [3:0] color;
	logic [7:0] tens;
	logic       adv;
	logic       emit;
	logic       done;
	logic       load;

	assign color = (ph_q == PH_FG) ? cur_q.attr[3:0] : cur_q.attr[7:4];
	assign tens  = (ph_q == PH_FG) ? CH_FG : CH_BG;

	always_comb begin
		byte_c  = CH_M;
		is_last = 1'b0;
		ph_d    = ph_q;
		sub_d   = sub_q + 3'd1;
		unique case (ph_q)
			PH_FG, PH_BG: begin
				case (sub_q)
					3'd0: byte_c = CH_ESC;
					3'd1: begin
						byte_c = CH_LBR;
						sub_d  = color[3] ? 3'd2 : 3'd4;
					end
					3'd2: byte_c = CH_ONE;
					3'd3: byte_c = CH_SEMI;
					3'd4: byte_c = tens;
					3'd5: byte_c = CH_ZERO + {5'b0, ansi_of_cga(color[2:0])};
					default: begin
						byte_c = CH_M;
						sub_d  = 3'd0;
						ph_d   = (ph_q == PH_FG) ? PH_BG : PH_CHAR;
					end
				endcase
			end
			PH_CHAR: begin
				byte_c  = cur_q.ch;
				sub_d   = 3'd0;
				ph_d    = PH_RST1;
				is_last = !cur_q.eol;
			end
			PH_RST1, PH_RST2: begin
				case (sub_q)
					3'd0: byte_c = CH_ESC;
					3'd1: byte_c = CH_LBR;
					3'd2: byte_c = CH_ZERO;
					3'd3: byte_c = CH_M;
					default: begin
						byte_c  = CH_NL;
						sub_d   = 3'd0;
						ph_d    = PH_RST2;
						is_last = (ph_q == PH_RST2) || !cur_q.eos;
					end
				endcase
			end
			default: begin
				byte_c  = CH_M;
				is_last = 1'b1;
			end
		endcase
	end

	assign adv      = !ov_q || pop;
	assign emit     = busy_q && adv;
	assign done     = emit && is_last;
	assign load     = !cmd_empty && (!busy_q || done);
	assign cmd_take = load;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= cmd;
		end
		if (emit) begin
			ob_q <= byte_c;
			ol_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= PH_CHAR;
			sub_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				ph_q   <= cmd.chg ? PH_FG : PH_CHAR;
				sub_q  <= '0;
			end else begin
				if (done) begin
					busy_q <= 1'b0;
				end
				if (emit) begin
					ph_q  <= ph_d;
					sub_q <= sub_d;
				end
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign empty     = !ov_q;
	assign out_byte  = ob_q;
	assign last_byte = ol_q;

endmodule

// ===== rtl/core/text_cell_to_ansi_escape.sv =====
// Top level of the text cell to ANSI terminal stream converter.
//
// Input side is a queue write port: a cell (cell_char, cell_attr) is taken
// at a clock edge with push high and full low. Output side is a queue read
// port: while empty is low, out_byte/last_byte show the oldest byte, and
// it is taken at an edge with pop high. last_byte marks a cell's final word.
// A cell expands to 1 to 25 words: an attribute change adds two color
// sequences (5 or 7 words each), a row end adds ESC[0m plus newline, and a
// screen end adds a second one.
// When the emitter is idle, a cell's first word passes the queue write,
// the emitter load and the output register before it appears.
// Words leave one per cycle while pop is high, set by the single output
// byte register, so a stalled receiver holds the stream.
// The front end runs ahead through a 4-entry command queue, so cells keep
// being accepted while the receiver stalls until that queue fills; full
// then holds the sender. Nothing is dropped on a stall.
// Reset clears attribute, column, row, the queue and the output valid flag.
module text_cell_to_ansi_escape import tcae_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] cell_char,
	input  logic [7:0] cell_attr,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_byte
);

	cmd_t fr_cmd;
	cmd_t q_cmd;
	logic q_full;
	logic q_empty;
	logic q_take;
	logic accept;

	assign accept = push && !q_full;
	assign full   = q_full;

	// front end: state tracking and cell classification
	tcae_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cell_char (cell_char),
		.cell_attr (cell_attr),
		.cmd       (fr_cmd)
	);

	// decoupling queue
	tcae_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (fr_cmd),
		.full   (q_full),
		.rd     (q_take),
		.rdata  (q_cmd),
		.empty  (q_empty)
	);

	// back end: byte sequencer with output register
	tcae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_empty (q_empty),
		.cmd_take  (q_take),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

// ===== rtl/core/tcae_checker.sv =====
// Port-level checks of the text cell converter and their bind.
`include "text_cell_to_ansi_escape_defines.svh"

module tcae_checker import tcae_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       last_byte
);

	logic prev_esc_q;

	// an escape that is not a cell's last word opens a sequence, or is a
	// character byte ending a row, which the reset sequence's escape follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_esc_q <= 1'b0;
		end else if (pop && !empty) begin
			prev_esc_q <= (out_byte == CH_ESC) && !last_byte;
		end
	end

	`TCAE_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (empty && !full), "not idle in reset")
	`TCAE_ASSERT(a_word_held, (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_byte)), "word changed while stalled")
	`TCAE_ASSERT(a_esc_bracket, (pop && !empty && prev_esc_q) |-> (out_byte == CH_LBR || out_byte == CH_ESC), "escape not followed by bracket")

endmodule

bind text_cell_to_ansi_escape tcae_checker u_tcae_checker (.*);

// ===== dv/tb_text_cell_to_ansi_escape.sv =====
// Testbench for the text cell to ANSI terminal stream converter.
`timescale 1ns / 1ps

module tb_text_cell_to_ansi_escape;
	import tcae_pkg::*;

	// One word of the terminal stream as it should leave the block.
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} term_word_t;

	// CGA color index to ANSI color index.
	localparam logic [2:0] CGA_TO_ANSI [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

	localparam int unsigned MAX_GAP     = 17;
	localparam int unsigned DRAIN_WAIT  = 8;
	localparam int unsigned RANDOM_CELLS = 180;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] cell_char;
	logic [7:0] cell_attr;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       last_byte;

	// Predictor state, mirrors what the block keeps between cells.
	logic [7:0]           shown_attr;
	logic [COL_W-1:0]     col_pos;
	logic [ROW_W-1:0]     row_pos;

	logic [7:0]  cell_words[$];    // words of the cell being expanded
	term_word_t  pending_words[$]; // words still owed by the block, oldest first

	int unsigned mismatches;
	logic        quiet_tx;         // sender stretch with no gaps
	logic        quiet_rx;         // receiver stretch with no stalls
	int unsigned tx_count;
	int unsigned rx_count;
	logic [7:0]  prev_attr;        // last attribute sent, for attribute reuse

	text_cell_to_ansi_escape i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cell_char (cell_char),
		.cell_attr (cell_attr),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void emit_word(input logic [7:0] b);
		cell_words.push_back(b);
	endfunction

	// ESC [ {1;} tens digit m  -- bright colors (8..15) get the bold prefix
	function automatic void emit_color(input logic [3:0] color, input logic [7:0] tens);
		emit_word(CH_ESC);
		emit_word(CH_LBR);
		if (color[3]) begin
			emit_word(CH_ONE);
			emit_word(CH_SEMI);
		end
		emit_word(tens);
		emit_word(CH_ZERO + {5'd0, CGA_TO_ANSI[color[2:0]]});
		emit_word(CH_M);
	endfunction

	// ESC [ 0 m newline
	function automatic void emit_reset_nl();
		emit_word(CH_ESC);
		emit_word(CH_LBR);
		emit_word(CH_ZERO);
		emit_word(CH_M);
		emit_word(CH_NL);
	endfunction

	// Works out every word one accepted cell produces and queues them.
	function automatic void expand_cell(input logic [7:0] ch, input logic [7:0] attr);
		cell_words.delete();
		if (attr != shown_attr) begin
			shown_attr = attr;
			emit_color(attr[3:0], CH_FG);
			emit_color(attr[7:4], CH_BG);
		end
		emit_word(ch);

		col_pos = col_pos + 1'b1;
		if (col_pos >= COLUMNS) begin
			// row end: reset sequence, newline, attribute forgotten
			col_pos    = '0;
			shown_attr = '0;
			emit_reset_nl();
			row_pos = row_pos + 1'b1;
			if (row_pos >= ROWS) begin
				// screen end: one more reset and newline, counters wrap
				row_pos = '0;
				emit_reset_nl();
			end
		end

		for (int i = 0; i < cell_words.size(); i++)
			pending_words.push_back('{cell_words[i], i == cell_words.size() - 1});
	endfunction

	// ------------------------------------------------------------------
	// Sender: one cell per call, random gap before it, push held across
	// back-to-back cells so it is never dropped and raised in one step.
	// ------------------------------------------------------------------
	task automatic send_cell(input logic [7:0] ch, input logic [7:0] attr);
		int unsigned gap;
		if (tx_count % 16 == 0)
			quiet_tx = ($urandom_range(0, 3) == 0);
		tx_count++;
		gap = quiet_tx ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		cell_char <= ch;
		cell_attr <= attr;
		do @(posedge clk); while (full);
		expand_cell(ch, attr);
		prev_attr = attr;
	endtask

	// Mostly keeps the running attribute so runs without escapes show up;
	// zero and fresh random attributes mixed in.
	function automatic logic [7:0] pick_attr();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return prev_attr;
		else if (roll < 70)
			return 8'h00;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked cells right after reset.
	task automatic test_directed();
		// attribute zero on the first cell: current attribute already zero, no escapes
		send_cell(8'h41, 8'h00);
		// lowest char, plain foreground
		send_cell(8'h00, 8'h07);
		// highest char, both colors bright
		send_cell(8'hff, 8'hff);
		// same attribute again: char only
		send_cell(8'h20, 8'hff);
		// every foreground once, bright and plain, against background 15 minus its index
		for (int i = 0; i < 16; i++)
			send_cell(8'h61 + 8'(i), {4'(15 - i), 4'(i)});
		// back to zero from a nonzero attribute: escapes with color 0
		send_cell(8'h7e, 8'h00);
	endtask

	// Random cells, enough for a couple of row ends.
	task automatic test_random();
		for (int i = 0; i < RANDOM_CELLS; i++)
			send_cell(8'($urandom_range(0, 255)), pick_attr());
	endtask

	// ------------------------------------------------------------------
	// Receiver and checker: random stall before each word, then compare
	// the word against the oldest expectation.
	// ------------------------------------------------------------------
	initial begin
		int unsigned stall;
		term_word_t  want;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_count % 24 == 0)
				quiet_rx = ($urandom_range(0, 3) == 0);
			rx_count++;
			stall = quiet_rx ? 0 : $urandom_range(0, MAX_GAP);
			@(negedge clk);
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (pending_words.size() == 0) begin
				$error("word 0x%02h (last %0b) with nothing expected", out_byte, last_byte);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				if (out_byte !== want.value) begin
					$error("out_byte: expected 0x%02h, got 0x%02h", want.value, out_byte);
					mismatches++;
				end
				if (last_byte !== want.last) begin
					$error("last_byte: expected %0b, got %0b", want.last, last_byte);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		cell_char    = 8'h00;
		cell_attr    = 8'h00;
		shown_attr   = 8'h00;
		col_pos      = '0;
		row_pos      = '0;
		mismatches   = 0;
		quiet_tx     = 1'b0;
		quiet_rx     = 1'b0;
		tx_count     = 0;
		rx_count     = 0;
		prev_attr    = 8'h00;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random();

		@(negedge clk);
		push <= 1'b0;
		// let every owed word come out, then watch for stray ones
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Hang guard: worst case is far below this even with every stall maxed out.
	initial begin
		#100_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
